@@ hdl/skq_pkg.sv @@
`default_nettype none

package skq_pkg;

    localparam int OP_BITS     = 2;
    localparam int KEY_IN_BITS = 32;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 7;

    typedef logic [OP_BITS-1:0]     t_op;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [KEY_IN_BITS-1:0] t_key_in;
    typedef logic [OCC_BITS-1:0]    t_occ;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_SEARCH = 2'd2;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ hdl/skq_if.sv @@
`default_nettype none

interface skq_in_if
    import skq_pkg::*;
();
    logic    valid;
    logic    ready;
    t_op     op;
    t_key_in key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface skq_out_if
    import skq_pkg::*;
();
    logic    valid;
    logic    ready;
    t_status status;
    logic    found;
    t_key_in removed_key;
    t_occ    occupancy;

    modport source (output valid, output status, output found, output removed_key,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input found, input removed_key,
                    input occupancy, output ready);
endinterface

`default_nettype wire

@@ hdl/skq_cell.sv @@
`default_nettype none

module skq_cell
    import skq_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_occupied,
    input  wire t_cell_cmd           i_cmd,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic                i_prev_lt,
    input  wire logic [KEY_BITS-1:0] i_prev_key,
    input  wire logic [KEY_BITS-1:0] i_next_key,
    output logic [KEY_BITS-1:0]      o_key,
    output logic                     o_lt,
    output logic                     o_match
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;

    assign o_lt    = i_occupied && (r_key < i_key);
    assign o_match = i_occupied && (r_key == i_key);
    assign o_key   = r_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins) begin
            if (o_lt) begin
                n_key = r_key;
            end else if (i_prev_lt) begin
                n_key = i_key;
            end else begin
                n_key = i_prev_key;
            end
        end else if (i_cmd.rem) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

@@ hdl/sorted_key_queue_top.sv @@
// channel   | dir | handshake     | payload
// i_req     | in  | valid / ready | op, key
// o_rsp     | out | valid / ready | status, found, removed_key, occupancy
//
// one transaction per cycle while o_rsp.ready is high; its result appears on o_rsp in the next cycle
// all cells compare against the key at once and shift left or right together
// reset clears the count and the result valid flag; cell contents stay unknown
// i_req.ready is high while the result register is empty or being taken
`default_nettype none

module sorted_key_queue_top
    import skq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    skq_in_if.sink     i_req,
    skq_out_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (KEY_BITS > KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic                r_found;
    logic                n_found;
    t_key_in             r_removed;
    t_key_in             n_removed;

    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic [WW-1:0]       w_key_wide;
    logic [WW-1:0]       w_front_wide;
    logic [KEY_BITS-1:0] w_key;
    t_cell_cmd           w_cmd;

    logic [KEY_BITS-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_match;

    assign i_req.ready  = !r_out_valid || o_rsp.ready;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_key_wide   = WW'(i_req.key);
    assign w_key        = w_key_wide[KEY_BITS-1:0];
    assign w_front_wide = WW'(w_cell_key[0]);

    assign w_cmd.ins = w_accept && (i_req.op == OP_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (i_req.op == OP_REMOVE) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                w_prev_lt;
        logic [KEY_BITS-1:0] w_prev_key;
        logic [KEY_BITS-1:0] w_next_key;

        if (g == 0) begin : g_first
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = w_cell_key[g];
        end else begin : g_inner
            assign w_prev_lt  = w_lt[g-1];
            assign w_prev_key = w_cell_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_key = w_cell_key[g];
        end else begin : g_body
            assign w_next_key = w_cell_key[g+1];
        end

        skq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_occupied (CW'(g) < r_count),
            .i_cmd      (w_cmd),
            .i_key      (w_key),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_next_key (w_next_key),
            .o_key      (w_cell_key[g]),
            .o_lt       (w_lt[g]),
            .o_match    (w_match[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_found   = 1'b0;
        n_removed = '0;
        case (i_req.op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - CW'(1);
                    n_removed = w_front_wide[KEY_IN_BITS-1:0];
                end
            end
            OP_SEARCH: begin
                n_found = |w_match;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_found   <= n_found;
            r_removed <= n_removed;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found       = r_found;
    assign o_rsp.removed_key = r_removed;
    assign o_rsp.occupancy   = OCC_BITS'(r_count);

endmodule

`default_nettype wire
